@@ hdl/four_way_page_tag_directory_top_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the page tag directory
// Shared property forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef FOUR_WAY_PAGE_TAG_DIRECTORY_TOP_ASSERT_SVH
`define FOUR_WAY_PAGE_TAG_DIRECTORY_TOP_ASSERT_SVH

// Same-cycle implication
`define FWPTD_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fwptd assertion failed (same cycle)");

// Next-cycle implication
`define FWPTD_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fwptd assertion failed (next cycle)");

`endif

@@ hdl/fwptd_pkg.sv @@
// ----------------------------------------------------------------------------
// fwptd_pkg
// Widths, codes and types of the four-way page tag directory.
// ----------------------------------------------------------------------------
`default_nettype none

package fwptd_pkg;

    // Geometry
    localparam int NUM_SETS = 1024;
    localparam int WAYS     = 4;
    localparam int SET_W    = $clog2(NUM_SETS);
    localparam int WAY_W    = $clog2(WAYS);
    localparam int SLOT_W   = SET_W + WAY_W;

    // Field widths
    localparam int ADDR_W  = 35;
    localparam int CADDR_W = 24;
    localparam int PL2_W   = 4;

    // Page size range
    localparam logic [PL2_W-1:0] PL2_MIN   = 4'd6;
    localparam logic [PL2_W-1:0] PL2_MAX   = 4'd12;
    localparam logic [PL2_W-1:0] PL2_RESET = 4'd12;
    localparam int PL2_MAX_I = 12;
    localparam int PL2_MIN_I = 6;

    localparam int OFS_W  = PL2_MAX_I;
    localparam int PAGE_W = ADDR_W - PL2_MIN_I;
    localparam int TAG_W  = PAGE_W - SET_W;

    // Command codes
    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_ALLOC  = 1'b1;

    // Front queue
    localparam int QUEUE_DEPTH = 2;
    localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    // Classified word passed from front to back
    typedef struct packed {
        logic              cmd;
        logic [SET_W-1:0]  set_idx;
        logic [TAG_W-1:0]  tag;
        logic [OFS_W-1:0]  offset;
        logic [PL2_W-1:0]  sh;
    } t_item;

    // Back-to-front control
    typedef struct packed {
        logic pop;
        logic clearing;
    } t_back_ctl;

    // One way of a set row
    typedef struct packed {
        logic             valid;
        logic [TAG_W-1:0] tag;
    } t_way_entry;

    typedef t_way_entry [WAYS-1:0] t_row;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_LOOK
    } t_back_state;

endpackage

`default_nettype wire

@@ hdl/fwptd_if.sv @@
// ----------------------------------------------------------------------------
// fwptd channel interfaces
// Request, response and configuration channels with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface fwptd_req_if;
    import fwptd_pkg::*;
    logic              valid;
    logic              ready;
    logic              cmd;
    logic [ADDR_W-1:0] remote_addr;
    modport source (output valid, output cmd, output remote_addr, input ready);
    modport sink   (input valid, input cmd, input remote_addr, output ready);
endinterface

interface fwptd_rsp_if;
    import fwptd_pkg::*;
    logic               valid;
    logic               ready;
    logic               hit;
    logic [WAY_W-1:0]   way;
    logic [CADDR_W-1:0] cache_addr;
    logic               victim_valid;
    logic [ADDR_W-1:0]  victim_addr;
    modport source (output valid, output hit, output way, output cache_addr,
                    output victim_valid, output victim_addr, input ready);
    modport sink   (input valid, input hit, input way, input cache_addr,
                    input victim_valid, input victim_addr, output ready);
endinterface

interface fwptd_cfg_if;
    import fwptd_pkg::*;
    logic             valid;
    logic             ready;
    logic [PL2_W-1:0] page_log2;
    modport source (output valid, output page_log2, input ready);
    modport sink   (input valid, input page_log2, output ready);
endinterface

`default_nettype wire

@@ hdl/four_way_page_tag_directory_top.sv @@
// ----------------------------------------------------------------------------
// four_way_page_tag_directory_top: four-way page tag directory
// Path: an accepted word passes the front queue, row fetch and result register.
// The back holds one word at a time, set by the read-modify-write of a tag row.
// Reset: a clearing pass over all 1024 tag rows holds request ready low.
// ----------------------------------------------------------------------------
`default_nettype none

module four_way_page_tag_directory_top (
    input  wire          i_clk,
    input  wire          i_rst_n,
    fwptd_req_if.sink    i_req,
    fwptd_cfg_if.sink    i_cfg,
    fwptd_rsp_if.source  o_rsp
);
    import fwptd_pkg::*;

    t_back_ctl back_ctl;
    t_item     item;
    logic      item_valid;

    // Front: accept and classify
    fwptd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .i_cfg        (i_cfg),
        .i_back_ctl   (back_ctl),
        .o_item_valid (item_valid),
        .o_item       (item)
    );

    // Back: lookup and allocate
    fwptd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (item_valid),
        .i_item       (item),
        .o_back_ctl   (back_ctl),
        .o_rsp        (o_rsp)
    );

endmodule

`default_nettype wire

@@ hdl/fwptd_queue.sv @@
// ----------------------------------------------------------------------------
// fwptd_queue
// Two-entry queue of classified words between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module fwptd_queue (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  fwptd_pkg::t_item    i_item,
    input  wire                 i_pop,
    output logic                o_full,
    output logic                o_valid,
    output fwptd_pkg::t_item    o_item
);
    import fwptd_pkg::*;

    t_item              r_q [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0] r_wp;
    logic [Q_PTR_W-1:0] r_rp;
    logic [Q_CNT_W-1:0] r_cnt;
    logic [Q_CNT_W-1:0] n_cnt;

    assign o_full  = (r_cnt == Q_CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_q[r_rp];

    // Track fill level
    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    // Advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

    // Store words
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_item;
        end
    end

endmodule

`default_nettype wire

@@ hdl/fwptd_front.sv @@
// ----------------------------------------------------------------------------
// fwptd_front
// Accept requests, split the address into set, tag and offset, and queue.
// ----------------------------------------------------------------------------
`default_nettype none

module fwptd_front (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    fwptd_req_if.sink             i_req,
    fwptd_cfg_if.sink             i_cfg,
    input  fwptd_pkg::t_back_ctl  i_back_ctl,
    output logic                  o_item_valid,
    output fwptd_pkg::t_item      o_item
);
    import fwptd_pkg::*;

    logic [PL2_W-1:0]  r_page_log2;
    logic [PL2_W-1:0]  sh;
    logic [ADDR_W-1:0] shifted;
    logic [PAGE_W-1:0] page;
    logic [OFS_W-1:0]  ofs_mask;
    t_item             cls_item;
    logic              q_full;
    logic              push;

    // Page size register
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_log2 <= PL2_RESET;
        end else if (i_cfg.valid) begin
            r_page_log2 <= i_cfg.page_log2;
        end
    end

    // Clamp page size into range
    always_comb begin
        if (r_page_log2 < PL2_MIN) begin
            sh = PL2_MIN;
        end else if (r_page_log2 > PL2_MAX) begin
            sh = PL2_MAX;
        end else begin
            sh = r_page_log2;
        end
    end

    // Classify the address
    assign shifted  = i_req.remote_addr >> sh;
    assign page     = shifted[PAGE_W-1:0];
    assign ofs_mask = ~({OFS_W{1'b1}} << sh);

    always_comb begin
        cls_item.cmd     = i_req.cmd;
        cls_item.set_idx = page[SET_W-1:0];
        cls_item.tag     = page[PAGE_W-1:SET_W];
        cls_item.offset  = i_req.remote_addr[OFS_W-1:0] & ofs_mask;
        cls_item.sh      = sh;
    end

    // Hold off requests while the back clears or the queue is full
    assign i_req.ready = !q_full && !i_back_ctl.clearing;
    assign push        = i_req.valid && i_req.ready;

    fwptd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (cls_item),
        .i_pop   (i_back_ctl.pop),
        .o_full  (q_full),
        .o_valid (o_item_valid),
        .o_item  (o_item)
    );

endmodule

`default_nettype wire

@@ hdl/fwptd_back.sv @@
// ----------------------------------------------------------------------------
// fwptd_back
// Tag memory, four-way compare, allocate and result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "four_way_page_tag_directory_top_assert.svh"

module fwptd_back (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_item_valid,
    input  fwptd_pkg::t_item      i_item,
    output fwptd_pkg::t_back_ctl  o_back_ctl,
    fwptd_rsp_if.source           o_rsp
);
    import fwptd_pkg::*;

    t_back_state        r_state;
    t_back_state        n_state;
    logic [SET_W-1:0]   r_clr_cnt;
    t_item              r_cur;
    t_row               r_mem [NUM_SETS];
    t_row               r_rd_row;

    logic               pop;
    logic               rd_en;
    logic               wr_en;
    logic [SET_W-1:0]   wr_addr;
    t_row               wr_row;
    logic               load_out;
    logic               out_free;

    logic [WAYS-1:0]    match;
    logic               hit_any;
    logic [WAY_W-1:0]   hit_way;
    logic               free_any;
    logic [WAY_W-1:0]   free_way;
    logic [WAY_W-1:0]   alloc_way;
    t_way_entry         old_entry;
    t_row               new_row;

    logic               res_hit;
    logic [WAY_W-1:0]   res_way;
    logic [CADDR_W-1:0] res_caddr;
    logic               res_vv;
    logic [ADDR_W-1:0]  res_vaddr;

    logic               r_out_valid;
    logic               r_out_hit;
    logic [WAY_W-1:0]   r_out_way;
    logic [CADDR_W-1:0] r_out_caddr;
    logic               r_out_victim_valid;
    logic [ADDR_W-1:0]  r_out_victim_addr;

    assign out_free = !r_out_valid || o_rsp.ready;

    // Compare and pick ways
    always_comb begin
        hit_any  = 1'b0;
        hit_way  = '0;
        free_any = 1'b0;
        free_way = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            match[w] = r_rd_row[w].valid && (r_rd_row[w].tag == r_cur.tag);
            if (match[w]) begin
                hit_any = 1'b1;
                hit_way = WAY_W'(w);
            end
            if (!r_rd_row[w].valid) begin
                free_any = 1'b1;
                free_way = WAY_W'(w);
            end
        end
        alloc_way = free_any ? free_way : r_cur.tag[WAY_W-1:0];
        old_entry = r_rd_row[alloc_way];
    end

    // Build result and new row
    always_comb begin
        new_row                 = r_rd_row;
        new_row[alloc_way]      = '{valid: 1'b1, tag: r_cur.tag};
        res_hit                 = 1'b0;
        res_way                 = '0;
        res_caddr               = '0;
        res_vv                  = 1'b0;
        res_vaddr               = '0;
        if (r_cur.cmd == CMD_ALLOC) begin
            res_way   = alloc_way;
            res_caddr = CADDR_W'({r_cur.set_idx, alloc_way}) << r_cur.sh;
            res_vv    = old_entry.valid;
            if (old_entry.valid) begin
                res_vaddr = ADDR_W'({old_entry.tag, r_cur.set_idx}) << r_cur.sh;
            end
        end else if (hit_any) begin
            res_hit   = 1'b1;
            res_way   = hit_way;
            res_caddr = (CADDR_W'({r_cur.set_idx, hit_way}) << r_cur.sh)
                        + CADDR_W'(r_cur.offset);
        end
    end

    // Sequencer: clear, fetch row, then compare and, on allocate, write back
    always_comb begin
        n_state  = r_state;
        pop      = 1'b0;
        rd_en    = 1'b0;
        wr_en    = 1'b0;
        wr_addr  = r_cur.set_idx;
        wr_row   = new_row;
        load_out = 1'b0;
        case (r_state)
            BK_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr_cnt;
                wr_row  = '0;
                if (r_clr_cnt == SET_W'(NUM_SETS - 1)) begin
                    n_state = BK_IDLE;
                end
            end
            BK_IDLE: begin
                if (i_item_valid) begin
                    pop     = 1'b1;
                    rd_en   = 1'b1;
                    n_state = BK_LOOK;
                end
            end
            BK_LOOK: begin
                if (out_free) begin
                    load_out = 1'b1;
                    wr_en    = (r_cur.cmd == CMD_ALLOC);
                    n_state  = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BK_CLEAR;
            r_clr_cnt <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == BK_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
        end
    end

    // Latch the popped word
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_cur <= i_item;
        end
    end

    // Tag memory, one row per set
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_row;
        end
        if (rd_en) begin
            r_rd_row <= r_mem[i_item.set_idx];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_hit          <= res_hit;
            r_out_way          <= res_way;
            r_out_caddr        <= res_caddr;
            r_out_victim_valid <= res_vv;
            r_out_victim_addr  <= res_vaddr;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.hit          = r_out_hit;
    assign o_rsp.way          = r_out_way;
    assign o_rsp.cache_addr   = r_out_caddr;
    assign o_rsp.victim_valid = r_out_victim_valid;
    assign o_rsp.victim_addr  = r_out_victim_addr;

    assign o_back_ctl.pop      = pop;
    assign o_back_ctl.clearing = (r_state == BK_CLEAR);

    // Checks
    `FWPTD_ASSERT_IMP(a_no_result_in_clear, i_clk, i_rst_n, r_state == BK_CLEAR, !r_out_valid)
    `FWPTD_ASSERT_NEXT(a_done_loads_result, i_clk, i_rst_n, r_state == BK_LOOK && out_free, r_out_valid)
    `FWPTD_ASSERT_NEXT(a_pop_fetches_row, i_clk, i_rst_n, r_state == BK_IDLE && i_item_valid, r_state == BK_LOOK)
    `FWPTD_ASSERT_IMP(a_victim_not_hit, i_clk, i_rst_n, r_out_valid && r_out_victim_valid, !r_out_hit)

endmodule

`default_nettype wire

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb: page tag directory testbench
// Drives lookup and allocate words into the four-way directory under random
// idling on both channels. It keeps a private copy of the tag and valid
// arrays to predict every response word, and checks each field in order.
// Page size is rewritten between phases, out-of-range values included.
// ----------------------------------------------------------------------------
module tb;
    import fwptd_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int IDLE_PCT    = 27;
    localparam int PHASE_WORDS = 115;

    typedef struct {
        logic              cmd;
        logic [ADDR_W-1:0] addr;
    } t_dir_request;

    typedef struct packed {
        logic               hit;
        logic [WAY_W-1:0]   way;
        logic [CADDR_W-1:0] cache_addr;
        logic               victim_valid;
        logic [ADDR_W-1:0]  victim_addr;
    } t_dir_reply;

    logic i_clk;
    logic i_rst_n;

    fwptd_req_if req_bus ();
    fwptd_rsp_if rsp_bus ();
    fwptd_cfg_if cfg_bus ();

    four_way_page_tag_directory_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .i_cfg   (cfg_bus),
        .o_rsp   (rsp_bus)
    );

    // Shadow directory and page size
    logic [TAG_W-1:0] way_tag   [NUM_SETS*WAYS];
    bit               way_valid [NUM_SETS*WAYS];
    logic [PL2_W-1:0] page_log2_q = PL2_RESET;

    t_dir_request request_backlog [$];
    t_dir_reply   replies_due     [$];
    int unsigned  mismatches    = 0;
    int unsigned  quiet_cycles  = 0;
    bit           steady_stretch = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int unsigned effective_shift(input logic [PL2_W-1:0] pl2);
        if (pl2 < PL2_MIN) return PL2_MIN_I;
        if (pl2 > PL2_MAX) return PL2_MAX_I;
        return int'(pl2);
    endfunction

    function automatic logic [ADDR_W-1:0] page_address(input logic [SET_W-1:0] set_no,
                                                       input logic [TAG_W-1:0] tag,
                                                       input int unsigned sh);
        return ADDR_W'(((64'(tag) << SET_W) | 64'(set_no)) << sh);
    endfunction

    // Resolve one word against the shadow directory, install on allocate
    function automatic t_dir_reply directory_access(input logic cmd,
                                                    input logic [ADDR_W-1:0] addr);
        int unsigned       sh;
        logic [63:0]       page;
        logic [63:0]       offset;
        logic [SET_W-1:0]  set_no;
        logic [TAG_W-1:0]  tag;
        logic [SLOT_W-1:0] slot;
        int                w;
        int                pick;
        t_dir_reply        r;
        sh     = effective_shift(page_log2_q);
        page   = 64'(addr) >> sh;
        set_no = page[SET_W-1:0];
        tag    = TAG_W'(page >> SET_W);
        offset = 64'(addr) & ((64'd1 << sh) - 1);
        r      = '0;
        if (cmd == CMD_LOOKUP) begin
            // scan downward so the lowest matching way wins
            for (w = WAYS - 1; w >= 0; w--) begin
                slot = {set_no, WAY_W'(w)};
                if (way_valid[slot] && way_tag[slot] == tag) begin
                    r.hit        = 1'b1;
                    r.way        = WAY_W'(w);
                    r.cache_addr = CADDR_W'((64'(slot) << sh) + offset);
                end
            end
        end else begin
            pick = -1;
            for (w = WAYS - 1; w >= 0; w--) begin
                if (!way_valid[{set_no, WAY_W'(w)}]) pick = w;
            end
            if (pick < 0) pick = int'(tag % WAYS);
            slot = {set_no, WAY_W'(pick)};
            if (way_valid[slot]) begin
                r.victim_valid = 1'b1;
                r.victim_addr  = page_address(set_no, way_tag[slot], sh);
            end
            way_tag[slot]   = tag;
            way_valid[slot] = 1'b1;
            r.way        = WAY_W'(pick);
            r.cache_addr = CADDR_W'(64'(slot) << sh);
        end
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] seen);
        if (seen !== want) begin
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, seen);
            mismatches++;
        end
    endfunction

    function automatic void queue_word(input logic cmd, input logic [ADDR_W-1:0] addr);
        t_dir_request q;
        q.cmd  = cmd;
        q.addr = addr;
        request_backlog.push_back(q);
    endfunction

    // Request driver: predict on acceptance, then present the next word
    always @(posedge i_clk) begin
        logic fire;
        fire = req_bus.valid && req_bus.ready;
        if (!i_rst_n) begin
            req_bus.valid <= 1'b0;
        end else begin
            if (fire) begin
                replies_due.push_back(directory_access(req_bus.cmd, req_bus.remote_addr));
                void'(request_backlog.pop_front());
            end
            // hold a word that has not been taken yet
            if (!req_bus.valid || fire) begin
                if (request_backlog.size() != 0 &&
                    (steady_stretch || $urandom_range(99) >= IDLE_PCT)) begin
                    req_bus.valid       <= 1'b1;
                    req_bus.cmd         <= request_backlog[0].cmd;
                    req_bus.remote_addr <= request_backlog[0].addr;
                end else begin
                    req_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Response monitor: compare with the oldest prediction, stall at random
    always @(posedge i_clk) begin
        t_dir_reply want;
        if (!i_rst_n) begin
            rsp_bus.ready <= 1'b0;
        end else begin
            if (rsp_bus.valid && rsp_bus.ready) begin
                if (replies_due.size() == 0) begin
                    $display("%0t: response word expected none, got hit=%0b way=%0d", $time,
                             rsp_bus.hit, rsp_bus.way);
                    mismatches++;
                end else begin
                    want = replies_due.pop_front();
                    check_field("hit", want.hit, rsp_bus.hit);
                    check_field("way", want.way, rsp_bus.way);
                    check_field("cache_addr", want.cache_addr, rsp_bus.cache_addr);
                    check_field("victim_valid", want.victim_valid, rsp_bus.victim_valid);
                    check_field("victim_addr", want.victim_addr, rsp_bus.victim_addr);
                end
            end
            rsp_bus.ready <= steady_stretch || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Watchdog: count cycles with no word moving on any channel
    always @(posedge i_clk) begin
        if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
            (cfg_bus.valid && cfg_bus.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic wait_drained();
        while (request_backlog.size() != 0 || replies_due.size() != 0 || req_bus.valid)
            @(posedge i_clk);
    endtask

    // Write the page size register once the directory is quiet
    task automatic write_page_log2(input logic [PL2_W-1:0] value);
        wait_drained();
        @(posedge i_clk);
        cfg_bus.valid     <= 1'b1;
        cfg_bus.page_log2 <= value;
        do @(posedge i_clk); while (!cfg_bus.ready);
        page_log2_q = value;
        cfg_bus.valid <= 1'b0;
    endtask

    // Mostly words on a few sets and tags so sets fill, hit and evict
    task automatic queue_random_words(input int unsigned count);
        int unsigned      sh;
        int unsigned      k;
        logic [TAG_W-1:0] tag_mask;
        logic [ADDR_W-1:0] ofs_mask;
        logic [SET_W-1:0] sets [6];
        logic [TAG_W-1:0] tags [8];
        sh       = effective_shift(page_log2_q);
        tag_mask = TAG_W'((64'd1 << (ADDR_W - sh - SET_W)) - 1);
        ofs_mask = ADDR_W'((64'd1 << sh) - 1);
        foreach (sets[i]) sets[i] = SET_W'($urandom);
        sets[0] = '0;
        sets[5] = '1;
        foreach (tags[i]) tags[i] = TAG_W'($urandom) & tag_mask;
        tags[0] = '0;
        tags[1] = tag_mask;
        for (k = 0; k < count; k++) begin
            if ($urandom_range(99) < 15) begin
                queue_word(1'($urandom), ADDR_W'({$urandom, $urandom}));
            end else begin
                queue_word(($urandom_range(99) < 35) ? CMD_ALLOC : CMD_LOOKUP,
                           page_address(sets[$urandom_range(5)], tags[$urandom_range(7)], sh)
                           | (ADDR_W'($urandom) & ofs_mask));
            end
        end
    endtask

    initial begin
        logic [PL2_W-1:0] phase_pl2 [10];
        int unsigned      p;
        phase_pl2 = '{4'd6, 4'd13, 4'd9, 4'd0, 4'd12, 4'd15, 4'd8, 4'd11, 4'd7, 4'd10};

        i_rst_n             = 1'b0;
        req_bus.valid       = 1'b0;
        req_bus.cmd         = CMD_LOOKUP;
        req_bus.remote_addr = '0;
        rsp_bus.ready       = 1'b0;
        cfg_bus.valid       = 1'b0;
        cfg_bus.page_log2   = PL2_RESET;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: largest pages, address extremes, full set and eviction
        write_page_log2(PL2_MAX);
        queue_word(CMD_LOOKUP, '0);
        queue_word(CMD_ALLOC, '0);
        queue_word(CMD_LOOKUP, ADDR_W'(12'hFFF));
        queue_word(CMD_LOOKUP, '1);
        queue_word(CMD_ALLOC, '1);
        queue_word(CMD_LOOKUP, '1);
        for (p = 1; p <= 4; p++) queue_word(CMD_ALLOC, page_address(SET_W'(5), TAG_W'(p), 12));
        queue_word(CMD_ALLOC, page_address(SET_W'(5), TAG_W'(6), 12));
        queue_word(CMD_LOOKUP, page_address(SET_W'(5), TAG_W'(3), 12));
        queue_word(CMD_LOOKUP, page_address(SET_W'(5), TAG_W'(6), 12) | ADDR_W'(12'h5A5));
        // allocate a page already present, then look it up
        queue_word(CMD_ALLOC, page_address(SET_W'(5), TAG_W'(1), 12));
        queue_word(CMD_LOOKUP, page_address(SET_W'(5), TAG_W'(1), 12));

        // Directed: page size below range is used as the smallest
        write_page_log2(4'd0);
        queue_word(CMD_ALLOC, page_address(SET_W'(77), TAG_W'(3), 6));
        queue_word(CMD_LOOKUP, page_address(SET_W'(77), TAG_W'(3), 6) | ADDR_W'(6'h3F));
        queue_word(CMD_ALLOC, '1);
        queue_word(CMD_LOOKUP, '1);
        queue_word(CMD_LOOKUP, '0);

        // Directed: page size above range is used as the largest
        write_page_log2(4'd15);
        queue_word(CMD_LOOKUP, '1);
        queue_word(CMD_LOOKUP, page_address(SET_W'(5), TAG_W'(6), 12));

        // Random phases, one of them with no idling on either side
        for (p = 0; p < 10; p++) begin
            write_page_log2(phase_pl2[p]);
            steady_stretch = (p == 3);
            queue_random_words(PHASE_WORDS);
        end
        wait_drained();
        steady_stretch = 1'b0;
        repeat (8) @(posedge i_clk);

        if (replies_due.size() != 0) begin
            $display("%0t: %0d response words never arrived", $time, replies_due.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
